// ----- rtl/acm_pkg.sv -----
// acm_pkg: shared types and constants of the anaglyph color matrix mixer.
// Holds the pixel item structs, coefficient bank, stage enables and widths.
// No dependencies.
package acm_pkg;

    // Coefficient format: signed fixed point, s1.14 by default
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_FRAC_BITS = 14;

    // Register and pixel widths
    localparam int REG_W    = 48;
    localparam int NUM_REGS = 6;
    localparam int IDX_W    = 3;
    localparam int PIX_W    = 8;
    localparam int PACK_W   = 3 * COEF_WIDTH;

    // Datapath widths: coef x (pixel with a zero sign bit), then sums
    localparam int PROD_W = COEF_WIDTH + PIX_W + 1;
    localparam int SUM3_W = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 4;
    localparam int QUO_W  = ACC_W - COEF_FRAC_BITS;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_LEFT_ROW_RED    = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_ROW_GREEN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEFT_ROW_BLUE   = 3'd2;
    localparam logic [IDX_W-1:0] REG_RIGHT_ROW_RED   = 3'd3;
    localparam logic [IDX_W-1:0] REG_RIGHT_ROW_GREEN = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_ROW_BLUE  = 3'd5;

    typedef logic [REG_W-1:0] t_row;

    typedef struct packed {
        logic [PIX_W-1:0] left_red;
        logic [PIX_W-1:0] left_green;
        logic [PIX_W-1:0] left_blue;
        logic [PIX_W-1:0] right_red;
        logic [PIX_W-1:0] right_green;
        logic [PIX_W-1:0] right_blue;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } t_pix_out;

    typedef struct packed {
        t_row left_red;
        t_row left_green;
        t_row left_blue;
        t_row right_red;
        t_row right_green;
        t_row right_blue;
    } t_coef_bank;

    // Load enables of the four pipeline stages
    typedef struct packed {
        logic mul;
        logic sum;
        logic acc;
        logic sat;
    } t_stage_en;

endpackage

// ----- rtl/acm_cfg.sv -----
// acm_cfg: the six coefficient row registers and their write port.
// Depends on acm_pkg.
module acm_cfg
    import acm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [IDX_W-1:0] i_index,
    input  t_row             i_data,
    output t_coef_bank       o_bank
);

    t_coef_bank r_bank;
    t_coef_bank n_bank;

    // Decode the index; indexes past the list are dropped
    always_comb begin
        n_bank = r_bank;
        if (i_wr) begin
            case (i_index)
                REG_LEFT_ROW_RED:    n_bank.left_red    = i_data;
                REG_LEFT_ROW_GREEN:  n_bank.left_green  = i_data;
                REG_LEFT_ROW_BLUE:   n_bank.left_blue   = i_data;
                REG_RIGHT_ROW_RED:   n_bank.right_red   = i_data;
                REG_RIGHT_ROW_GREEN: n_bank.right_green = i_data;
                REG_RIGHT_ROW_BLUE:  n_bank.right_blue  = i_data;
                default:             n_bank = r_bank;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= '0;
        end else begin
            r_bank <= n_bank;
        end
    end

    assign o_bank = r_bank;

endmodule

// ----- rtl/acm_lane.sv -----
// acm_lane: datapath of one output channel, four register stages:
// multiply, partial sums, total plus rounding, clamp. Depends on acm_pkg.
module acm_lane
    import acm_pkg::*;
(
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  t_pix_in          i_pix,
    input  t_row             i_lrow,
    input  t_row             i_rrow,
    output logic [PIX_W-1:0] o_value
);

    // Coefficient k of a row; bits past the register read as zero
    function automatic logic signed [COEF_WIDTH-1:0] coef_at(t_row row, int k);
        logic [PACK_W-1:0] ext;
        ext = PACK_W'(row);
        return ext[k*COEF_WIDTH +: COEF_WIDTH];
    endfunction

    logic [PIX_W-1:0] w_lpix [3];
    logic [PIX_W-1:0] w_rpix [3];

    logic signed [PROD_W-1:0] r_lprod [3];
    logic signed [PROD_W-1:0] r_rprod [3];
    logic signed [PROD_W-1:0] n_lprod [3];
    logic signed [PROD_W-1:0] n_rprod [3];
    logic signed [SUM3_W-1:0] r_lsum, r_rsum, n_lsum, n_rsum;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [PIX_W-1:0]         r_value, n_value;
    logic [QUO_W-1:0]         w_quo;

    assign w_lpix[0] = i_pix.left_red;
    assign w_lpix[1] = i_pix.left_green;
    assign w_lpix[2] = i_pix.left_blue;
    assign w_rpix[0] = i_pix.right_red;
    assign w_rpix[1] = i_pix.right_green;
    assign w_rpix[2] = i_pix.right_blue;

    // Stage 1: six products, pixel taken as a non-negative signed value
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lprod[k] = coef_at(i_lrow, k) * $signed({1'b0, w_lpix[k]});
            n_rprod[k] = coef_at(i_rrow, k) * $signed({1'b0, w_rpix[k]});
        end
    end

    // Stage 2: left and right partial sums
    always_comb begin
        n_lsum = SUM3_W'(r_lprod[0]) + SUM3_W'(r_lprod[1]) + SUM3_W'(r_lprod[2]);
        n_rsum = SUM3_W'(r_rprod[0]) + SUM3_W'(r_rprod[1]) + SUM3_W'(r_rprod[2]);
    end

    // Stage 3: exact total plus half an LSB for round-to-nearest
    assign n_acc = ACC_W'(r_lsum) + ACC_W'(r_rsum) + ROUND_HALF;

    // Stage 4: drop the fraction and clamp to the pixel range once
    assign w_quo = r_acc[ACC_W-1:COEF_FRAC_BITS];

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            n_value = '0;
        end else if (w_quo > QUO_W'(PIX_MAX)) begin
            n_value = PIX_MAX;
        end else begin
            n_value = w_quo[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_lprod <= n_lprod;
            r_rprod <= n_rprod;
        end
        if (i_en.sum) begin
            r_lsum <= n_lsum;
            r_rsum <= n_rsum;
        end
        if (i_en.acc) begin
            r_acc <= n_acc;
        end
        if (i_en.sat) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ----- rtl/anaglyph_color_matrix_mix.sv -----
// Anaglyph color matrix mixer: 3x3 left and right matrices, one pixel pair in,
// one RGB pixel out, through the mul, sum, acc and sat stage registers.
// Throughput: one item per cycle unless i_stall holds the pipe; the four
// stages each hold with a valid bit and a held stage only stops the stages
// behind it, so bubbles close up. Reset (synchronous, active low) clears
// all valid bits and zeroes the coefficient rows. Config port is always ready.
module anaglyph_color_matrix_mix
    import acm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_pix_in          i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_pix_out         o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  t_row             i_cfg_data
);

    t_coef_bank w_bank;
    t_stage_en  w_en;
    logic [3:0] r_vld;
    logic [3:0] n_vld;

    assign o_cfg_ready = 1'b1;

    acm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_bank  (w_bank)
    );

    // Stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        w_en.sat = !r_vld[3] || !i_stall;
        w_en.acc = !r_vld[2] || w_en.sat;
        w_en.sum = !r_vld[1] || w_en.acc;
        w_en.mul = !r_vld[0] || w_en.sum;
    end

    assign o_stall = !w_en.mul;

    // Valid bits follow the data
    always_comb begin
        n_vld = r_vld;
        if (w_en.mul) n_vld[0] = i_valid;
        if (w_en.sum) n_vld[1] = r_vld[0];
        if (w_en.acc) n_vld[2] = r_vld[1];
        if (w_en.sat) n_vld[3] = r_vld[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[3];

    // One lane per output channel
    acm_lane u_lane_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_data),
        .i_lrow  (w_bank.left_red),
        .i_rrow  (w_bank.right_red),
        .o_value (o_data.out_red)
    );

    acm_lane u_lane_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_data),
        .i_lrow  (w_bank.left_green),
        .i_rrow  (w_bank.right_green),
        .o_value (o_data.out_green)
    );

    acm_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pix   (i_data),
        .i_lrow  (w_bank.left_blue),
        .i_rrow  (w_bank.right_blue),
        .o_value (o_data.out_blue)
    );

    // An accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted item lost at stage 1");

    // An empty output register never pushes back on the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |-> !o_stall)
        else $error("input stalled with output empty");

    // A held first stage keeps its item
    a_hold_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] && !w_en.sum |=> r_vld[0])
        else $error("stage 1 item dropped while held");

    // An item moving out of stage 3 reaches the output register
    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && w_en.sat |=> r_vld[3])
        else $error("item lost entering output register");

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for the anaglyph color matrix mixer.
// Drives pixel pairs and coefficient rows, predicts each mixed pixel in SV.
// Depends on acm_pkg and anaglyph_color_matrix_mix.
module tb;
    import acm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the last row: writes there must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES = 12;
    localparam int MIX_PHASES   = 9;
    localparam int PHASE_ITEMS  = 48;

    typedef enum {COEF_RAW, COEF_MILD, COEF_EDGE} t_coef_style;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    t_pix_in          i_data      = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    t_pix_out         o_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = '0;
    t_row             i_cfg_data  = '0;

    // Shadow copy of the coefficient rows, indexed by register index
    t_row     coef_rows [NUM_REGS] = '{default: '0};
    t_pix_out mixed_pixel_q [$];
    int       mismatch_count = 0;
    bit       calm = 1'b0;
    int       stall_left = 0;

    anaglyph_color_matrix_mix u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint coef_of(t_row row, int k);
        logic [63:0]                   wide;
        logic signed [COEF_WIDTH-1:0]  c;
        wide = 64'(row) >> (k * COEF_WIDTH);
        c    = wide[COEF_WIDTH-1:0];
        return longint'(c);
    endfunction

    // Expected mixed pixel: exact sum, round half up, single final clamp
    function automatic t_pix_out mix_pixel(t_pix_in px);
        logic [PIX_W-1:0] lp [3];
        logic [PIX_W-1:0] rp [3];
        logic [PIX_W-1:0] ch [3];
        longint           sum;
        longint           q;
        t_pix_out         res;
        lp = '{px.left_red, px.left_green, px.left_blue};
        rp = '{px.right_red, px.right_green, px.right_blue};
        for (int c = 0; c < 3; c++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                sum += coef_of(coef_rows[REG_LEFT_ROW_RED + c], k) * longint'(lp[k]);
                sum += coef_of(coef_rows[REG_RIGHT_ROW_RED + c], k) * longint'(rp[k]);
            end
            sum += longint'(1) <<< (COEF_FRAC_BITS - 1);
            if (sum < 0) begin
                ch[c] = '0;
            end else begin
                q     = sum >>> COEF_FRAC_BITS;
                ch[c] = (q > longint'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];
            end
        end
        res.out_red   = ch[0];
        res.out_green = ch[1];
        res.out_blue  = ch[2];
        return res;
    endfunction

    function automatic t_row coef_row(int r, int g, int b);
        logic [COEF_WIDTH-1:0] cr, cg, cb;
        cr = r[COEF_WIDTH-1:0];
        cg = g[COEF_WIDTH-1:0];
        cb = b[COEF_WIDTH-1:0];
        return t_row'({cb, cg, cr});
    endfunction

    function automatic t_row random_row(t_coef_style style);
        int c [3];
        if (style == COEF_RAW) return t_row'({$urandom, $urandom});
        for (int k = 0; k < 3; k++) begin
            if (style == COEF_MILD) begin
                c[k] = int'($urandom_range(0, 12288)) - 4096;
            end else begin
                case ($urandom_range(0, 4))
                    0: c[k] = 32767;
                    1: c[k] = -32768;
                    2: c[k] = -1;
                    3: c[k] = 16384;
                    default: c[k] = 0;
                endcase
            end
        end
        return coef_row(c[0], c[1], c[2]);
    endfunction

    function automatic t_pix_in pix(int lr, int lg, int lb, int rr, int rg, int rb);
        t_pix_in p;
        p.left_red    = lr[PIX_W-1:0];
        p.left_green  = lg[PIX_W-1:0];
        p.left_blue   = lb[PIX_W-1:0];
        p.right_red   = rr[PIX_W-1:0];
        p.right_green = rg[PIX_W-1:0];
        p.right_blue  = rb[PIX_W-1:0];
        return p;
    endfunction

    function automatic t_pix_in random_pixel();
        int ch [6];
        bit edgy;
        edgy = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < 6; k++) begin
            ch[k] = int'($urandom_range(0, 255));
            if (edgy && $urandom_range(0, 1)) ch[k] = $urandom_range(0, 1) ? int'(PIX_MAX) : 0;
        end
        return pix(ch[0], ch[1], ch[2], ch[3], ch[4], ch[5]);
    endfunction

    // Send one item; entered and left at a falling edge, valid left high
    task automatic send_pixel(input t_pix_in px);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_data  <= t_pix_in'({$urandom, $urandom});
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        mixed_pixel_q.push_back(mix_pixel(px));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every mixed pixel has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (mixed_pixel_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_row(input logic [IDX_W-1:0] idx, input t_row val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= REG_RIGHT_ROW_BLUE) coef_rows[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic load_rows(input t_row lr, lg, lb, rr, rg, rb);
        wait_drained();
        write_row(REG_LEFT_ROW_RED, lr);
        write_row(REG_LEFT_ROW_GREEN, lg);
        write_row(REG_LEFT_ROW_BLUE, lb);
        write_row(REG_RIGHT_ROW_RED, rr);
        write_row(REG_RIGHT_ROW_GREEN, rg);
        write_row(REG_RIGHT_ROW_BLUE, rb);
        i_cfg_valid <= 1'b0;
    endtask

    // Rows are zero after reset: every channel rounds to zero
    task automatic test_reset_rows();
        send_pixel(pix(255, 255, 255, 255, 255, 255));
        send_pixel(pix(17, 200, 99, 3, 128, 250));
    endtask

    // Common presets: true, gray, color, half color, optimized, Dubois
    task automatic test_presets();
        t_row lum, zero, g1, b1;
        lum  = coef_row(4899, 9617, 1868);
        zero = '0;
        g1   = coef_row(0, 16384, 0);
        b1   = coef_row(0, 0, 16384);
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_rows(lum, zero, zero, zero, zero, lum);
                1: load_rows(lum, zero, zero, zero, lum, lum);
                2: load_rows(coef_row(16384, 0, 0), zero, zero, zero, g1, b1);
                3: load_rows(lum, zero, zero, zero, g1, b1);
                4: load_rows(coef_row(0, 11469, 4915), zero, zero, zero, g1, b1);
                default: load_rows(coef_row(7160, 7356, 2687),
                                   coef_row(-1016, -1016, -393),
                                   coef_row(-786, -819, -279),
                                   coef_row(-180, -524, -115),
                                   coef_row(6177, 12468, 147),
                                   coef_row(-426, -1524, 20218));
            endcase
            send_pixel(pix(255, 128, 0, 0, 128, 255));
            send_pixel(pix(37, 200, 90, 220, 15, 160));
        end
    endtask

    // Largest and most negative coefficients: clamp at both ends
    task automatic test_clamp_extremes();
        t_row pmax, nmax;
        pmax = coef_row(32767, 32767, 32767);
        nmax = coef_row(-32768, -32768, -32768);
        load_rows(pmax, pmax, pmax, pmax, pmax, pmax);
        send_pixel(pix(255, 255, 255, 255, 255, 255));
        send_pixel(pix(1, 1, 1, 1, 1, 1));
        load_rows(nmax, nmax, nmax, nmax, nmax, nmax);
        send_pixel(pix(255, 255, 255, 255, 255, 255));
        send_pixel(pix(0, 0, 0, 0, 0, 0));
        load_rows(pmax, nmax, pmax, nmax, pmax, nmax);
        send_pixel(pix(255, 255, 255, 0, 0, 0));
        send_pixel(pix(0, 0, 0, 255, 255, 255));
        send_pixel(pix(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    endtask

    // Exact halves round up; a negative half lands on zero
    task automatic test_rounding();
        load_rows(coef_row(8192, 0, 0), coef_row(16384, 0, 0), coef_row(-8192, 0, 0),
                  '0, coef_row(-8192, 0, 0), '0);
        send_pixel(pix(1, 0, 0, 1, 0, 0));
        send_pixel(pix(3, 0, 0, 1, 0, 0));
        send_pixel(pix(2, 0, 0, 4, 0, 0));
    endtask

    // Writes past the last row leave every row untouched
    task automatic test_spare_index();
        wait_drained();
        write_row(REG_SPARE_LO, '1);
        write_row(REG_SPARE_HI, '1);
        i_cfg_valid <= 1'b0;
        send_pixel(pix(3, 0, 0, 1, 0, 0));
        send_pixel(pix(255, 255, 255, 255, 255, 255));
    endtask

    // Random rows in several styles, random pixel streams
    task automatic test_random_mix();
        t_coef_style style;
        for (int ph = 0; ph < MIX_PHASES; ph++) begin
            style = t_coef_style'(ph % 3);
            load_rows(random_row(style), random_row(style), random_row(style),
                      random_row(style), random_row(style), random_row(style));
            calm = (ph == 4 || ph == 7);
            repeat (PHASE_ITEMS) send_pixel(random_pixel());
            calm = 1'b0;
        end
    endtask

    // Output back-pressure: random stalls, no new stall run starts while calm
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left = pick_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each accepted item with the oldest expected pixel
    always @(posedge i_clk) begin : check_result
        t_pix_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mixed_pixel_q.size() == 0) begin
                $display("%0t: unexpected item r %0d g %0d b %0d", $time,
                         o_data.out_red, o_data.out_green, o_data.out_blue);
                mismatch_count++;
            end else begin
                want = mixed_pixel_q.pop_front();
                if (o_data !== want) begin
                    $display("%0t: mismatch exp r %0d g %0d b %0d, got r %0d g %0d b %0d",
                             $time, want.out_red, want.out_green, want.out_blue,
                             o_data.out_red, o_data.out_green, o_data.out_blue);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_rows();
        test_presets();
        test_clamp_extremes();
        test_rounding();
        test_spare_index();
        test_random_mix();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- anaglyph_color_matrix_mix.f -----
rtl/acm_pkg.sv
rtl/acm_cfg.sv
rtl/acm_lane.sv
rtl/anaglyph_color_matrix_mix.sv
verif/tb.sv
